@@ hdl/egc_pkg.sv @@
// ----------------------------------------------------------------------------
// egc_pkg: shared types and codes for the Eulerian graph classifier
// Command and result words, operation and verdict codes, sequencer states.
// ----------------------------------------------------------------------------
package egc_pkg;

    localparam int VERTEX_W  = 5;
    localparam int NUM_V_W   = 6;
    localparam int VERDICT_W = 2;
    localparam int ODD_W     = 6;

    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_EVALUATE = 1'b1;

    localparam logic [VERDICT_W-1:0] VERDICT_NONE  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_PATH  = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_CYCLE = 2'd2;

    localparam logic [NUM_V_W-1:0] NUM_V_RESET = 6'd32;

    typedef struct packed {
        logic                op;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
    } egc_in_t;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [ODD_W-1:0]     odd_count;
    } egc_out_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SWEEP
    } egc_state_t;

endpackage

@@ hdl/eulerian_graph_classifier.sv @@
// ----------------------------------------------------------------------------
// eulerian_graph_classifier: Euler path / cycle test on an undirected graph
// Edge words set bits in an adjacency matrix; an evaluate word walks the rows.
// ----------------------------------------------------------------------------
// Edge words: taken only while idle, busy stays low (1 word/cycle while idle).
// Evaluate: a scan of all MAX_VERTICES rows (start vertex, odd count), then, unless
// no vertex is used, P sweep passes over all MAX_VERTICES rows, one adjacency row per
// cycle, P = growing passes + 1 (at most MAX_VERTICES); done pulses the cycle after.
// The receiver cannot stall: result is updated with done and holds until the next evaluate ends.
// Reset (rst_n low, async) empties the graph and sets num_vertices to 32.
module eulerian_graph_classifier
    import egc_pkg::*;
#(
    parameter int MAX_VERTICES = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  egc_in_t            cmd,
    output logic               done,
    output egc_out_t           result,
    input  logic               cfg_we,
    input  logic [NUM_V_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    logic [MAX_VERTICES-1:0] adj_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] odd_reg;
    logic [MAX_VERTICES-1:0] used_reg;
    logic [MAX_VERTICES-1:0] reached_reg, reached_next;
    logic [NUM_V_W-1:0]      num_v_reg;

    egc_state_t state_reg, state_next;
    logic [IDX_W-1:0] v_reg, v_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             found_reg, found_next;
    logic             changed_reg, changed_next;
    logic             done_reg, done_next;
    egc_out_t         result_reg, result_next;

    logic             add_edge;
    logic             clear_store;
    logic             a_ok, b_ok;
    logic [IDX_W-1:0] a_idx, b_idx;
    logic [MAX_VERTICES-1:0] a_bit, b_bit;
    logic             last_v;
    logic [MAX_VERTICES-1:0] grown;
    logic             chg;

    assign a_idx  = IDX_W'(cmd.vertex_a);
    assign b_idx  = IDX_W'(cmd.vertex_b);
    assign a_bit  = MAX_VERTICES'(1) << a_idx;
    assign b_bit  = MAX_VERTICES'(1) << b_idx;
    assign a_ok   = (NUM_V_W'(cmd.vertex_a) < num_v_reg) && (int'(cmd.vertex_a) < MAX_VERTICES);
    assign b_ok   = (NUM_V_W'(cmd.vertex_b) < num_v_reg) && (int'(cmd.vertex_b) < MAX_VERTICES);
    assign last_v = (v_reg == IDX_W'(MAX_VERTICES - 1));

    // in-place growth: rows of vertices reached earlier in this pass count too
    assign grown = reached_reg | (reached_reg[v_reg] ? adj_reg[v_reg] : '0);
    assign chg   = changed_reg | (grown != reached_reg);

    always_comb
    begin
        state_next   = state_reg;
        v_next       = v_reg;
        cnt_next     = cnt_reg;
        found_next   = found_reg;
        changed_next = changed_reg;
        reached_next = reached_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        add_edge     = 1'b0;
        clear_store  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.op == OP_EVALUATE)
                    begin
                        state_next   = S_SCAN;
                        v_next       = '0;
                        cnt_next     = '0;
                        found_next   = 1'b0;
                        reached_next = '0;
                    end
                    else
                    begin
                        add_edge = a_ok && b_ok;
                    end
                end
            end

            S_SCAN:
            begin
                cnt_next = cnt_reg + CNT_W'(odd_reg[v_reg]);
                if (!found_reg && used_reg[v_reg])
                begin
                    reached_next = MAX_VERTICES'(1) << v_reg;
                    found_next   = 1'b1;
                end
                if (last_v)
                begin
                    v_next       = '0;
                    changed_next = 1'b0;
                    if (!found_next)
                    begin
                        // no edges at all
                        result_next.verdict   = VERDICT_CYCLE;
                        result_next.odd_count = ODD_W'(cnt_next);
                        done_next             = 1'b1;
                        clear_store           = 1'b1;
                        state_next            = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SWEEP;
                    end
                end
                else
                begin
                    v_next = v_reg + IDX_W'(1);
                end
            end

            S_SWEEP:
            begin
                reached_next = grown;
                changed_next = chg;
                if (last_v)
                begin
                    v_next       = '0;
                    changed_next = 1'b0;
                    if (!chg)
                    begin
                        result_next.odd_count = ODD_W'(cnt_reg);
                        if (|(used_reg & ~grown))
                            result_next.verdict = VERDICT_NONE;
                        else if (cnt_reg > CNT_W'(2))
                            result_next.verdict = VERDICT_NONE;
                        else if (cnt_reg != '0)
                            result_next.verdict = VERDICT_PATH;
                        else
                            result_next.verdict = VERDICT_CYCLE;
                        done_next   = 1'b1;
                        clear_store = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    v_next = v_reg + IDX_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            v_reg       <= '0;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            changed_reg <= 1'b0;
            done_reg    <= 1'b0;
            num_v_reg   <= NUM_V_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            v_reg       <= v_next;
            cnt_reg     <= cnt_next;
            found_reg   <= found_next;
            changed_reg <= changed_next;
            done_reg    <= done_next;
            if (cfg_we)
                num_v_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // graph store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
                adj_reg[i] <= '0;
            odd_reg     <= '0;
            used_reg    <= '0;
            reached_reg <= '0;
        end
        else if (clear_store)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
                adj_reg[i] <= '0;
            odd_reg     <= '0;
            used_reg    <= '0;
            reached_reg <= '0;
        end
        else
        begin
            reached_reg <= reached_next;
            if (add_edge)
            begin
                for (int i = 0; i < MAX_VERTICES; i++)
                    adj_reg[i] <= adj_reg[i] | (a_bit[i] ? b_bit : '0) | (b_bit[i] ? a_bit : '0);
                used_reg <= used_reg | a_bit | b_bit;
                // a self-loop adds two to the degree
                if (cmd.vertex_a != cmd.vertex_b)
                    odd_reg <= odd_reg ^ a_bit ^ b_bit;
            end
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
